### rtl/core/ppi_pkg.sv
// shared types and constants for the planar pose integrator
// state encoding, register indexes, item kinds and the cordic angle table
// no dependencies
`default_nettype none

package ppi_pkg;

  // item kinds carried on in_tuser
  localparam logic OP_VELOCITY = 1'b0;
  localparam logic OP_TICK     = 1'b1;

  // configuration register indexes
  localparam logic REG_SPEED_SCALE = 1'b0;
  localparam logic REG_TURN_GAIN   = 1'b1;

  localparam logic [15:0] SPEED_SCALE_RST = 16'd19071;
  localparam logic [7:0]  TURN_GAIN_RST   = 8'd10;

  // cordic gain pre-compensation, 0.607252935 in Q1.30
  localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

  localparam int ANGLE_W = 25;
  localparam int ANGLE_TAB_LEN = 24;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT,
    ST_QUAD,
    ST_M_VXC,
    ST_M_VYS,
    ST_M_VXS,
    ST_M_VYC,
    ST_M_XSC,
    ST_M_YSC,
    ST_M_XDT,
    ST_M_YDT,
    ST_M_HDT,
    ST_FIN,
    ST_EMIT
  } state_t;

  // atan(2^-i) in 2^-24 turn
  function automatic logic signed [ANGLE_W-1:0] cordic_angle(input logic [4:0] idx);
    logic signed [ANGLE_W-1:0] a;
    case (idx)
      5'd0:    a = 25'sd2097152;
      5'd1:    a = 25'sd1238021;
      5'd2:    a = 25'sd654136;
      5'd3:    a = 25'sd332050;
      5'd4:    a = 25'sd166669;
      5'd5:    a = 25'sd83416;
      5'd6:    a = 25'sd41718;
      5'd7:    a = 25'sd20860;
      5'd8:    a = 25'sd10430;
      5'd9:    a = 25'sd5215;
      5'd10:   a = 25'sd2608;
      5'd11:   a = 25'sd1304;
      5'd12:   a = 25'sd652;
      5'd13:   a = 25'sd326;
      5'd14:   a = 25'sd163;
      5'd15:   a = 25'sd81;
      5'd16:   a = 25'sd41;
      5'd17:   a = 25'sd20;
      5'd18:   a = 25'sd10;
      5'd19:   a = 25'sd5;
      5'd20:   a = 25'sd3;
      5'd21:   a = 25'sd1;
      5'd22:   a = 25'sd1;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### rtl/core/planar_pose_integrator_top.sv
// planar pose integrator, top level
// iterative cordic plus one shared multiplier under a small sequencer
// depends on ppi_pkg
//
// usage
//   in_*  : one transfer per item. in_tuser is the kind (0 velocity, 1 tick).
//           in_tdata carries lin_x, lin_y, yaw_rate and elapsed.
//   out_* : one transfer per tick carrying the pose and the stored velocities.
//   cfg_* : write-only registers, index 0 speed_scale, index 1 turn_gain;
//           write only while the block is idle.
// sequence
//   a velocity item updates the stored velocities and gives no result.
//   a tick occupies the block through the transfer, CORDIC_STEPS steps of the
//   shift-add rotation loop, a quadrant fold, nine passes through the shared
//   34x21 multiplier, then heading update and output load.
//   in_tready is high only while the sequencer is idle.
// stall
//   the result sits in an output register, so the next item is accepted while
//   it waits; a second tick completing before the first result is taken holds
//   in its last step until out_tready frees the register.
// reset
//   rst_n (synchronous) clears pose, velocities, the sequencer and restores
//   speed_scale = 1.164 (Q2.14) and turn_gain = 10.
`default_nettype none

module planar_pose_integrator_top
  import ppi_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // lin_x[15:0], lin_y[31:16], yaw_rate[47:32], elapsed[67:48], zero pad
  input  wire logic [71:0]  in_tdata,
  // op[0]
  input  wire logic         in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], vel_x[95:80], vel_y[111:96],
  // turn_rate[135:112]
  output logic [135:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [15:0]  cfg_wdata
);

  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  // input fields
  logic signed [15:0] in_lin_x;
  logic signed [15:0] in_lin_y;
  logic signed [15:0] in_yaw_rate;
  logic [19:0]        in_elapsed;

  assign in_lin_x    = in_tdata[15:0];
  assign in_lin_y    = in_tdata[31:16];
  assign in_yaw_rate = in_tdata[47:32];
  assign in_elapsed  = in_tdata[67:48];

  // registers
  state_t state_r, state_nxt;
  logic [15:0] speed_scale_r;
  logic [7:0]  turn_gain_r;
  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic [15:0] heading_r, heading_nxt;
  logic signed [15:0] vel_x_r, vel_x_nxt;
  logic signed [15:0] vel_y_r, vel_y_nxt;
  logic signed [23:0] turn_r, turn_nxt;
  logic [19:0] dt_r, dt_nxt;
  logic [1:0]  quad_r, quad_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic signed [31:0] cx_r, cx_nxt;
  logic signed [31:0] cy_r, cy_nxt;
  logic signed [ANGLE_W-1:0] cz_r, cz_nxt;
  logic signed [31:0] cos_r, cos_nxt;
  logic signed [31:0] sin_r, sin_nxt;
  logic signed [54:0] prod_r, prod_nxt;
  logic signed [54:0] acc_r, acc_nxt;
  logic signed [33:0] tx_r, tx_nxt;
  logic signed [33:0] ty_r, ty_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [135:0] out_data_r, out_data_nxt;

  // datapath helpers
  logic in_fire;
  logic out_fire;
  logic out_load;
  logic [15:0] head_off;
  logic signed [13:0] resid;
  logic signed [31:0] cx_sh;
  logic signed [31:0] cy_sh;
  logic signed [ANGLE_W-1:0] angle;
  logic signed [33:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [54:0] diff_w;
  logic signed [54:0] sum_w;
  logic signed [54:0] rnd16_d;
  logic signed [54:0] rnd16_s;
  logic signed [54:0] rnd14;
  logic signed [54:0] rnd26;
  logic signed [54:0] rnd20;
  logic signed [31:0] pos_sel;
  logic signed [34:0] pos_sum;
  logic signed [31:0] pos_sat;
  logic signed [24:0] vel_turn;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_fire   = out_valid_r && out_tready;
  assign out_load   = (state_r == ST_EMIT) && (!out_valid_r || out_tready);

  // quadrant fold of the current heading
  assign head_off = heading_r + 16'd8192;
  assign resid    = {~head_off[13], head_off[12:0]};

  // cordic shift-add unit
  assign cx_sh = cx_r >>> iter_r;
  assign cy_sh = cy_r >>> iter_r;
  assign angle = cordic_angle(5'(iter_r));

  // rounding taps on the product register
  assign diff_w  = acc_r - prod_r;
  assign sum_w   = acc_r + prod_r;
  assign rnd16_d = (diff_w + 55'sd32768) >>> 16;
  assign rnd16_s = (sum_w + 55'sd32768) >>> 16;
  assign rnd14   = (prod_r + 55'sd8192) >>> 14;
  assign rnd26   = (prod_r + 55'sd33554432) >>> 26;
  assign rnd20   = (prod_r + 55'sd524288) >>> 20;

  assign vel_turn = in_yaw_rate * $signed({1'b0, turn_gain_r});

  // saturating position add
  assign pos_sel = (state_r == ST_M_YDT) ? pos_x_r : pos_y_r;
  assign pos_sum = 35'(pos_sel) + 35'(rnd26);
  always_comb begin
    if (pos_sum > 35'sd2147483647) begin
      pos_sat = 32'sh7fffffff;
    end else if (pos_sum < -35'sd2147483648) begin
      pos_sat = 32'sh80000000;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_tuser == OP_TICK)) begin
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (iter_r == ITER_LAST) begin
          state_nxt = ST_QUAD;
        end
      end
      ST_QUAD:  state_nxt = ST_M_VXC;
      ST_M_VXC: state_nxt = ST_M_VYS;
      ST_M_VYS: state_nxt = ST_M_VXS;
      ST_M_VXS: state_nxt = ST_M_VYC;
      ST_M_VYC: state_nxt = ST_M_XSC;
      ST_M_XSC: state_nxt = ST_M_YSC;
      ST_M_YSC: state_nxt = ST_M_XDT;
      ST_M_XDT: state_nxt = ST_M_YDT;
      ST_M_YDT: state_nxt = ST_M_HDT;
      ST_M_HDT: state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_M_VXC: begin
        mul_a = 34'(cos_r);
        mul_b = 21'(vel_x_r);
      end
      ST_M_VYS: begin
        mul_a = 34'(sin_r);
        mul_b = 21'(vel_y_r);
      end
      ST_M_VXS: begin
        mul_a = 34'(sin_r);
        mul_b = 21'(vel_x_r);
      end
      ST_M_VYC: begin
        mul_a = 34'(cos_r);
        mul_b = 21'(vel_y_r);
      end
      ST_M_XSC: begin
        mul_a = tx_r;
        mul_b = {5'b0, speed_scale_r};
      end
      ST_M_YSC: begin
        mul_a = ty_r;
        mul_b = {5'b0, speed_scale_r};
      end
      ST_M_XDT: begin
        mul_a = tx_r;
        mul_b = {1'b0, dt_r};
      end
      ST_M_YDT: begin
        mul_a = ty_r;
        mul_b = {1'b0, dt_r};
      end
      ST_M_HDT: begin
        mul_a = 34'(turn_r);
        mul_b = {1'b0, dt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  // datapath register updates
  always_comb begin
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    heading_nxt   = heading_r;
    vel_x_nxt     = vel_x_r;
    vel_y_nxt     = vel_y_r;
    turn_nxt      = turn_r;
    dt_nxt        = dt_r;
    quad_nxt      = quad_r;
    iter_nxt      = iter_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    cos_nxt       = cos_r;
    sin_nxt       = sin_r;
    acc_nxt       = acc_r;
    tx_nxt        = tx_r;
    ty_nxt        = ty_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == OP_TICK) begin
            dt_nxt   = in_elapsed;
            quad_nxt = head_off[15:14];
            iter_nxt = '0;
            cx_nxt   = CORDIC_X0;
            cy_nxt   = '0;
            cz_nxt   = {{3{resid[13]}}, resid, 8'b0};
          end else begin
            vel_x_nxt = in_lin_x;
            vel_y_nxt = in_lin_y;
            turn_nxt  = vel_turn[23:0];
          end
        end
      end
      ST_ROT: begin
        // z >= 0 rotates positive
        if (!cz_r[ANGLE_W-1]) begin
          cx_nxt = cx_r - cy_sh;
          cy_nxt = cy_r + cx_sh;
          cz_nxt = cz_r - angle;
        end else begin
          cx_nxt = cx_r + cy_sh;
          cy_nxt = cy_r - cx_sh;
          cz_nxt = cz_r + angle;
        end
        iter_nxt = iter_r + 1'b1;
      end
      ST_QUAD: begin
        case (quad_r)
          2'd0: begin
            cos_nxt = cx_r;
            sin_nxt = cy_r;
          end
          2'd1: begin
            cos_nxt = -cy_r;
            sin_nxt = cx_r;
          end
          2'd2: begin
            cos_nxt = -cx_r;
            sin_nxt = -cy_r;
          end
          default: begin
            cos_nxt = cy_r;
            sin_nxt = -cx_r;
          end
        endcase
      end
      ST_M_VYS: acc_nxt = prod_r;
      ST_M_VXS: tx_nxt  = rnd16_d[33:0];
      ST_M_VYC: acc_nxt = prod_r;
      ST_M_XSC: ty_nxt  = rnd16_s[33:0];
      ST_M_YSC: tx_nxt  = rnd14[33:0];
      ST_M_XDT: ty_nxt  = rnd14[33:0];
      ST_M_YDT: pos_x_nxt = pos_sat;
      ST_M_HDT: pos_y_nxt = pos_sat;
      ST_FIN:   heading_nxt = heading_r + rnd20[15:0];
      ST_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {turn_r, vel_y_r, vel_x_r, heading_r, pos_y_r, pos_x_r};
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      speed_scale_r <= SPEED_SCALE_RST;
      turn_gain_r   <= TURN_GAIN_RST;
      pos_x_r       <= '0;
      pos_y_r       <= '0;
      heading_r     <= '0;
      vel_x_r       <= '0;
      vel_y_r       <= '0;
      turn_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      heading_r   <= heading_nxt;
      vel_x_r     <= vel_x_nxt;
      vel_y_r     <= vel_y_nxt;
      turn_r      <= turn_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SPEED_SCALE: speed_scale_r <= cfg_wdata;
          REG_TURN_GAIN:   turn_gain_r   <= cfg_wdata[7:0];
          default:         turn_gain_r   <= turn_gain_r;
        endcase
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    dt_r       <= dt_nxt;
    quad_r     <= quad_nxt;
    iter_r     <= iter_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    cos_r      <= cos_nxt;
    sin_r      <= sin_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    tx_r       <= tx_nxt;
    ty_r       <= ty_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

### bench/ppi_pose_checker.sv
`timescale 1ns / 1ps
// pose checker for the planar pose integrator: watches the item, result and register ports,
// predicts each tick result in fixed point and compares it field by field
// depends on ppi_pkg
module ppi_pose_checker
  import ppi_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  // lin_x[15:0], lin_y[31:16], yaw_rate[47:32], elapsed[67:48], zero pad
  input  wire logic [71:0]  in_tdata,
  // op[0]
  input  wire logic         in_tuser,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], vel_x[95:80], vel_y[111:96],
  // turn_rate[135:112]
  input  wire logic [135:0] out_tdata,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic [15:0]  cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        heading;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [23:0] turn_rate;
  } pose_t;

  pose_t expected_poses[$];

  logic signed [31:0] x_pos, y_pos;
  logic [15:0]        heading;
  logic signed [15:0] fwd_speed, side_speed;
  logic signed [23:0] turn_rate;
  logic [15:0]        scale_q14;
  logic [7:0]         gain;

  // atan(2^-i) in 2^-24 turn
  longint atan_q24 [0:23] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  function automatic longint rshift_round(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // unit vector of the heading in Q1.30: fold to a quadrant, rotate the residual
  function automatic void rotate_unit(input logic [15:0] h, output longint co,
                                      output longint si);
    logic [16:0] hh;
    longint x, y, z, xs, ys;
    hh = {1'b0, h} + 17'd8192;
    x = 652032874;
    y = 0;
    z = (longint'(hh[13:0]) - 8192) * 256;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_q24[i];
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_q24[i];
      end
    end
    case (hh[15:14])
      2'd0: begin co = x;  si = y;  end
      2'd1: begin co = -y; si = x;  end
      2'd2: begin co = -x; si = -y; end
      default: begin co = y; si = -x; end
    endcase
  endfunction

  // rotated speed in Q30 * 2^-8 m/s to distance in 2^-16 m
  function automatic longint travel(input longint e, input logic [19:0] dt);
    longint t;
    t = rshift_round(e, 16);
    t = rshift_round(t * longint'(scale_q14), 14);
    return rshift_round(t * longint'(dt), 26);
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < 40) $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic store_velocity(input logic [71:0] d);
    logic signed [15:0] yaw_in;
    longint turn_full;
    yaw_in = d[47:32];
    fwd_speed = d[15:0];
    side_speed = d[31:16];
    turn_full = longint'(yaw_in) * longint'(gain);
    turn_rate = turn_full[23:0];
  endtask

  task automatic integrate_tick(input logic [19:0] dt);
    longint co, si, ex, ey, dh;
    pose_t p;
    // the rotation uses the heading from before the tick
    rotate_unit(heading, co, si);
    ex = longint'(fwd_speed) * co - longint'(side_speed) * si;
    ey = longint'(fwd_speed) * si + longint'(side_speed) * co;
    x_pos = clamp32(longint'(x_pos) + travel(ex, dt));
    y_pos = clamp32(longint'(y_pos) + travel(ey, dt));
    dh = rshift_round(longint'(turn_rate) * longint'(dt), 20);
    heading = heading + dh[15:0];
    p.pos_x = x_pos;
    p.pos_y = y_pos;
    p.heading = heading;
    p.vel_x = fwd_speed;
    p.vel_y = side_speed;
    p.turn_rate = turn_rate;
    expected_poses.push_back(p);
  endtask

  task automatic check_pose(input logic [135:0] d);
    pose_t w;
    if (expected_poses.size() == 0) begin
      report_mismatch($sformatf("result with no tick waiting, data %h", d));
    end else begin
      w = expected_poses.pop_front();
      if ($signed(d[31:0]) != w.pos_x)
        report_mismatch($sformatf("pos_x got %0d expected %0d", $signed(d[31:0]), w.pos_x));
      if ($signed(d[63:32]) != w.pos_y)
        report_mismatch($sformatf("pos_y got %0d expected %0d", $signed(d[63:32]), w.pos_y));
      if (d[79:64] != w.heading)
        report_mismatch($sformatf("heading got %0d expected %0d", d[79:64], w.heading));
      if ($signed(d[95:80]) != w.vel_x)
        report_mismatch($sformatf("vel_x got %0d expected %0d", $signed(d[95:80]), w.vel_x));
      if ($signed(d[111:96]) != w.vel_y)
        report_mismatch($sformatf("vel_y got %0d expected %0d", $signed(d[111:96]), w.vel_y));
      if ($signed(d[135:112]) != w.turn_rate)
        report_mismatch($sformatf("turn_rate got %0d expected %0d",
                                  $signed(d[135:112]), w.turn_rate));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      x_pos = '0;
      y_pos = '0;
      heading = '0;
      fwd_speed = '0;
      side_speed = '0;
      turn_rate = '0;
      scale_q14 = SPEED_SCALE_RST;
      gain = TURN_GAIN_RST;
      fail_count = 0;
      expected_poses.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_SPEED_SCALE) scale_q14 = cfg_wdata;
        else if (cfg_addr == REG_TURN_GAIN) gain = cfg_wdata[7:0];
      end
      if (out_tvalid && out_tready) check_pose(out_tdata);
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_VELOCITY) store_velocity(in_tdata);
        else integrate_tick(in_tdata[67:48]);
      end
    end
    pending = expected_poses.size();
  end

endmodule

### bench/tb_planar_pose_integrator_top.sv
`timescale 1ns / 1ps
// testbench top for the planar pose integrator: clock, reset, item and register stimulus
// and the verdict; depends on ppi_pkg, planar_pose_integrator_top and ppi_pose_checker
module tb_planar_pose_integrator_top;
  import ppi_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int CLK_PERIOD = 12;
  localparam int HOLD_CYCLES = 400;
  localparam longint TIMEOUT_CYCLES = 800000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [71:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         cfg_we;
  logic         cfg_addr;
  logic [15:0]  cfg_wdata;

  int fail_count;
  int pending;
  int items_sent;
  bit no_idle;
  int hold_reqs;
  int hold_seen;
  int hold_left;

  planar_pose_integrator_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  ppi_pose_checker #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb_planar_pose_integrator_top failed");
    $finish;
  end

  // result side: random back-pressure, plus a long hold-off whenever one is requested
  initial begin
    out_tready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
        out_tready = 1'b0;
      end else begin
        out_tready = no_idle || ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic send_item(input logic op, input logic [15:0] lx, input logic [15:0] ly,
                           input logic [15:0] yr, input logic [19:0] dt);
    while (!no_idle && $urandom_range(99) < 11) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = {4'b0, dt, yr, ly, lx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_velocity(input logic [15:0] lx, input logic [15:0] ly,
                               input logic [15:0] yr);
    send_item(OP_VELOCITY, lx, ly, yr, 20'($urandom));
  endtask

  task automatic send_tick(input logic [19:0] dt);
    send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), dt);
  endtask

  function automatic logic [19:0] pick_elapsed();
    case ($urandom_range(9))
      0: return 20'd0;
      1: return 20'hfffff;
      2: return 20'($urandom_range(255));
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic wait_all_results();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // velocity items give no result, so allow a full tick time before touching registers
  task automatic drain();
    wait_all_results();
    repeat (CORDIC_STEPS + 20) @(negedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] data);
    cfg_we = 1'b1;
    cfg_addr = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic run_directed();
    send_tick(20'hfffff);                      // no velocity yet, pose stays put
    send_tick(20'd0);
    send_velocity(16'sh7fff, 16'sh8000, 16'sh7fff);
    send_tick(20'hfffff);
    send_tick(20'd0);                          // zero elapsed still gives a result
    send_tick(20'd1);
    send_velocity(16'sh8000, 16'sh7fff, 16'sh8000);
    repeat (3) send_tick(20'hfffff);
    send_velocity(16'sh0000, 16'sh0000, 16'sh0000);
    send_tick(20'hfffff);
    // slow turn so the heading walks through the quadrants
    send_velocity(16'sh0100, 16'sh0000, 16'sh4000);
    repeat (4) send_tick(20'h40000);
    send_velocity(16'shffff, 16'shffff, 16'shffff);
    send_tick(20'hfffff);
    send_tick(20'h80000);
  endtask

  task automatic run_random(input int n);
    int stop;
    int kind;
    logic [15:0] lx;
    stop = items_sent + n;
    while (items_sent < stop) begin
      kind = $urandom_range(99);
      if (kind < 6) begin
        // straight dash at full speed, long enough to pin a position at its limit
        lx = $urandom_range(1) ? 16'(16'sh7fff - $urandom_range(255))
                               : 16'(16'sh8000 + $urandom_range(255));
        send_velocity(lx, 16'($signed(8'($urandom))), 16'd0);
        repeat ($urandom_range(80, 200))
          if (items_sent < stop) send_tick(20'($urandom_range(20'he0000, 20'hfffff)));
      end else if (kind < 14) begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    20'($urandom));
      end else if (kind < 20) begin
        // velocity updates with no tick between them
        repeat ($urandom_range(2, 4))
          send_velocity(16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        send_velocity(16'($urandom), 16'($urandom), 16'($urandom));
        repeat ($urandom_range(1, 8)) send_tick(pick_elapsed());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = OP_VELOCITY;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_addr = REG_SPEED_SCALE;
    cfg_wdata = '0;
    no_idle = 1'b0;
    hold_reqs = 0;
    items_sent = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(REG_SPEED_SCALE, 16'hffff);
          write_reg(REG_TURN_GAIN, 16'h00ff);
        end
        1: begin
          write_reg(REG_SPEED_SCALE, 16'h0000);
          write_reg(REG_TURN_GAIN, 16'h0000);
        end
        2: begin
          write_reg(REG_SPEED_SCALE, 16'h4000);
          write_reg(REG_TURN_GAIN, 16'h0001);
        end
        3: begin
          // upper bits of the gain write are dropped
          write_reg(REG_SPEED_SCALE, 16'd19071);
          write_reg(REG_TURN_GAIN, 16'hff0a);
        end
        default: begin
          write_reg(REG_SPEED_SCALE, 16'($urandom));
          write_reg(REG_TURN_GAIN, 16'($urandom));
        end
      endcase
      no_idle = (p == 2);
      if (p == 0 || p == 3) hold_reqs++;
      run_random(128);
      wait_all_results();
      run_random(127);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb_planar_pose_integrator_top passed");
    end else begin
      $display("tb_planar_pose_integrator_top failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ppi_pkg.sv
rtl/core/planar_pose_integrator_top.sv
bench/ppi_pose_checker.sv
bench/tb_planar_pose_integrator_top.sv
